@@ hw/rtl/pur_pkg.sv @@
// ----------------------------------------------------------------------------
// pur_pkg
// shared constants and types of the polyline resampler
// ----------------------------------------------------------------------------
package pur_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int COORD_WIDTH_DEF  = 24;
   localparam int TOL_WIDTH        = 24;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 24'd256;

   // divider operand width: covers 2*(2^32*64)+n and 2*len+tol
   localparam int DIV_WIDTH = 42;

   // request to and answer from the shared divider
   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] num;
      logic [DIV_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quo;
   } div_rsp_type;

endpackage

@@ hw/rtl/pur_sqrt.sv @@
// ----------------------------------------------------------------------------
// pur_sqrt
// bit-serial rounded square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pur_sqrt #(
   parameter int IN_WIDTH  = 68,
   parameter int OUT_WIDTH = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IN_WIDTH-1:0]  radicand,
   output logic                 done,
   output logic [OUT_WIDTH-1:0] root
);

   localparam int RW    = IN_WIDTH + 2;
   localparam int TOPB  = 2 * ((IN_WIDTH - 1) / 2);   // highest even bit of the radicand
   localparam int STEPS = TOPB / 2 + 1;
   localparam int CW    = $clog2(STEPS + 1);

   logic [IN_WIDTH-1:0]  rem_ff, rem_in;
   logic [IN_WIDTH-1:0]  q_ff, q_in;
   logic [IN_WIDTH-1:0]  bit_ff, bit_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic [RW-1:0]        trial;
   logic [RW-1:0]        qext;

   // restoring digit-by-digit root over bit pairs
   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      qext    = RW'(q_ff);
      trial   = RW'(rem_ff) - (qext + RW'(bit_ff));
      if (start) begin
         rem_in  = radicand;
         q_in    = '0;
         bit_in  = IN_WIDTH'(1) << TOPB;
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[RW-1]) begin
            rem_in = trial[IN_WIDTH-1:0];
            q_in   = IN_WIDTH'((qext >> 1) + RW'(bit_ff));
         end else begin
            q_in = IN_WIDTH'(qext >> 1);
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   // round up when remainder exceeds the root (s > q*q + q)
   assign done = fin_ff;
   assign root = OUT_WIDTH'(q_ff + IN_WIDTH'(rem_ff > q_ff));

endmodule

@@ hw/rtl/pur_div.sv @@
// ----------------------------------------------------------------------------
// pur_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pur_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pur_pkg::div_req_type req,
   output pur_pkg::div_rsp_type rsp
);

   localparam int W  = pur_pkg::DIV_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // shift in one numerator bit and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = fin_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ hw/rtl/polyline_uniform_resample.sv @@
// ----------------------------------------------------------------------------
// polyline_uniform_resample
// 3d polyline resampler: emits evenly spaced points along long edges
// ----------------------------------------------------------------------------
// Each vertex is taken, then the block stays busy until all its points are
// transferred. A line start goes straight to output of its vertex. A later
// vertex runs one squared-difference step per axis on a shared multiplier, a
// bit-serial root and a divide for the count; a short edge thus only emits its
// vertex. Each interior point then needs three divide steps, one per axis, on
// the one shared divider and an output transfer that waits for rsp_ready.
module polyline_uniform_resample #(
   parameter int MAX_SEGMENTS = pur_pkg::MAX_SEGMENTS_DEF,
   parameter int COORD_WIDTH  = pur_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,
   input  logic                                req_starts_line,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_z,
   output logic                                rsp_last_of_run,
   output logic                                rsp_count_clamped,
   input  logic                                csr_we,
   input  logic [pur_pkg::TOL_WIDTH-1:0]       csr_wdata
);

   localparam int W   = pur_pkg::DIV_WIDTH;
   localparam int DW  = COORD_WIDTH + 1;          // signed difference width
   localparam int MW  = COORD_WIDTH;              // magnitude width
   localparam int SW  = 2 * MW + 2;               // sum of squares width
   localparam int RTW = MW + 2;                   // root width
   localparam int NW  = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SQ    = 9'b000000010,
      S_ROOT  = 9'b000000100,
      S_NDIV  = 9'b000001000,
      S_NWAIT = 9'b000010000,
      S_PDIV  = 9'b000100000,
      S_PWAIT = 9'b001000000,
      S_EMIT  = 9'b010000000,
      S_LAST  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [pur_pkg::TOL_WIDTH-1:0] tol_ff;
   logic [COORD_WIDTH-1:0] prev_ff [3];
   logic [COORD_WIDTH-1:0] cur_ff [3];
   logic signed [DW-1:0]   d_ff [3];
   logic                   have_prev_ff;
   logic [SW-1:0]          sum_ff;
   logic [1:0]             axis_ff;
   logic [RTW-1:0]         len_ff;
   logic [NW-1:0]          n_ff;
   logic [NW-1:0]          j_ff;
   logic                   clamp_ff;
   logic [COORD_WIDTH-1:0] pt_ff [3];
   logic                   sq_start;
   logic                   sq_done;
   logic [RTW-1:0]         root;
   pur_pkg::div_req_type   dreq;
   pur_pkg::div_rsp_type   drsp;
   logic [pur_pkg::TOL_WIDTH-1:0] tol_eff;
   logic [MW-1:0]          mag_sel;
   logic [2*MW-1:0]        sq_prod;
   logic [MW+NW-1:0]       mj;
   logic [COORD_WIDTH:0]   dsel;
   logic [W-1:0]           qn;
   logic [COORD_WIDTH-1:0] interp;
   logic                   accept;

   assign tol_eff = (tol_ff == '0) ? pur_pkg::TOL_WIDTH'(1) : tol_ff;
   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // shared multiplier operand: one axis magnitude per cycle in S_SQ, one per divide step for the points
   assign dsel    = d_ff[axis_ff];
   assign mag_sel = dsel[DW-1] ? MW'(-dsel) : MW'(dsel);
   assign sq_prod = mag_sel * mag_sel;
   assign mj      = mag_sel * j_ff;
   assign sq_start = (state_ff == S_SQ) && (axis_ff == 2'd2);

   // divider operands
   always_comb begin
      dreq.start = 1'b0;
      dreq.num   = '0;
      dreq.den   = '0;
      if (state_ff == S_NDIV) begin
         dreq.start = 1'b1;
         dreq.num   = W'({len_ff, 1'b0}) + W'(tol_eff);
         dreq.den   = W'({tol_eff, 1'b0});
      end else if (state_ff == S_PDIV) begin
         dreq.start = 1'b1;
         dreq.num   = W'({mj, 1'b0}) + W'(n_ff);
         dreq.den   = W'({n_ff, 1'b0});
      end
   end

   // rounded quotient applied toward the new vertex
   assign qn     = drsp.quo;
   assign interp = dsel[DW-1] ? prev_ff[axis_ff] - COORD_WIDTH'(qn)
                              : prev_ff[axis_ff] + COORD_WIDTH'(qn);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = (req_starts_line || !have_prev_ff) ? S_LAST : S_SQ;
         S_SQ:    if (axis_ff == 2'd2) state_in = S_ROOT;
         S_ROOT:  if (sq_done) state_in = S_NDIV;
         S_NDIV:  state_in = (len_ff > RTW'(tol_eff)) ? S_NWAIT : S_LAST;
         S_NWAIT: if (drsp.done) state_in = S_PDIV;
         S_PDIV:  state_in = (j_ff >= n_ff) ? S_LAST : S_PWAIT;
         S_PWAIT: if (drsp.done) state_in = (axis_ff == 2'd2) ? S_EMIT : S_PDIV;
         S_EMIT:  if (rsp_ready) state_in = S_PDIV;
         S_LAST:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= pur_pkg::TOL_RESET;
         have_prev_ff <= 1'b0;
         clamp_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) prev_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) tol_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (accept) begin
               clamp_ff <= 1'b0;
               cur_ff[0] <= req_point_x;
               cur_ff[1] <= req_point_y;
               cur_ff[2] <= req_point_z;
               for (int i = 0; i < 3; i++) begin
                  d_ff[i] <= DW'(signed'(i == 0 ? req_point_x
                                       : i == 1 ? req_point_y : req_point_z))
                           - DW'(signed'(prev_ff[i]));
               end
               axis_ff <= 2'd0;
               sum_ff  <= '0;
            end
            S_SQ: begin
               sum_ff  <= sum_ff + SW'(sq_prod);
               axis_ff <= axis_ff + 2'd1;
            end
            S_ROOT: if (sq_done) len_ff <= root;
            S_NDIV: j_ff <= NW'(1);
            S_NWAIT: if (drsp.done) begin
               if (qn > W'(MAX_SEGMENTS)) begin
                  n_ff     <= NW'(MAX_SEGMENTS);
                  clamp_ff <= 1'b1;
               end else begin
                  n_ff <= NW'(qn);
               end
               axis_ff <= 2'd0;
            end
            S_PWAIT: if (drsp.done) begin
               pt_ff[axis_ff] <= interp;
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
            S_EMIT: if (rsp_ready) j_ff <= j_ff + 1'b1;
            S_LAST: if (rsp_ready) begin
               for (int i = 0; i < 3; i++) prev_ff[i] <= cur_ff[i];
               have_prev_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   pur_sqrt #(
      .IN_WIDTH  (SW),
      .OUT_WIDTH (RTW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff + SW'(sq_prod)),
      .done     (sq_done),
      .root     (root)
   );

   pur_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // output transfer
   assign rsp_valid         = (state_ff == S_EMIT) || (state_ff == S_LAST);
   assign rsp_last_of_run   = (state_ff == S_LAST);
   assign rsp_count_clamped = clamp_ff;
   assign rsp_out_x = (state_ff == S_LAST) ? cur_ff[0] : pt_ff[0];
   assign rsp_out_y = (state_ff == S_LAST) ? cur_ff[1] : pt_ff[1];
   assign rsp_out_z = (state_ff == S_LAST) ? cur_ff[2] : pt_ff[2];

endmodule
